@@ hw/rtl/umean_pkg.sv @@
// Shared types and constants for the unsigned 16-bit mean block.
package umean_pkg;

   // Largest number of samples counted in one set
   localparam logic [15:0] MAX_ELEMENTS = 16'd65535;

   // Divider: one quotient bit per step, quotient fits 16 bits
   localparam int DIV_STEPS = 16;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   // Input word
   typedef struct packed {
      logic [15:0] sample;
      logic        last;
      logic        empty_set;
   } umean_req_type;

   // Result word
   typedef struct packed {
      logic [15:0] mean;
      logic        overflow;
   } umean_rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic acc_en;       // add the input sample to the running set
      logic clear;        // drop the set (empty-set word)
      logic div_load;     // load divider from the finished set
      logic div_step;     // one restoring division step
      logic out_load_div; // result register takes the quotient
      logic out_load_zero;// result register takes the empty-set result
   } umean_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic out_free;     // result register can take a word this cycle
      logic item_last;
      logic item_empty;
   } umean_sts_type;

endpackage

@@ hw/rtl/umean_ctrl.sv @@
// Controller state machine for the unsigned 16-bit mean block.
module umean_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output umean_pkg::umean_cmd_type cmd,
   input  umean_pkg::umean_sts_type sts
);
   import umean_pkg::*;

   localparam logic [1:0] ST_ACC  = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_cnt_ff, step_cnt_in;
   logic              accept;

   // Input words are taken only while accumulating and the result side can drain
   assign req_stall = (state_ff != ST_ACC) || !sts.out_free;
   assign accept    = req_valid && !req_stall;

   // Next state and commands
   always_comb begin
      state_in    = state_ff;
      step_cnt_in = step_cnt_ff;
      cmd         = '0;
      case (state_ff)
         ST_ACC: begin
            if (accept) begin
               if (sts.item_empty) begin
                  cmd.clear         = 1'b1;
                  cmd.out_load_zero = 1'b1;
               end else begin
                  cmd.acc_en = 1'b1;
                  if (sts.item_last) begin
                     cmd.div_load = 1'b1;
                     step_cnt_in  = '0;
                     state_in     = ST_DIV;
                  end
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            step_cnt_in  = step_cnt_ff + 1'b1;
            if (step_cnt_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.out_load_div = 1'b1;
               state_in         = ST_ACC;
            end
         end
         default: begin
            state_in = ST_ACC;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_ACC;
         step_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         step_cnt_ff <= step_cnt_in;
      end
   end

`ifndef NO_ASSERTIONS
   // Result register is only loaded when it can take a word
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load_div || cmd.out_load_zero) |-> sts.out_free)
      else $error("result loaded while result register blocked");

   // A division run starts only from a loaded divider
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && step_cnt_ff == '0) |-> $past(cmd.div_load))
      else $error("division started without a load");

   // The controller reaches the done state right after the last step
   a_div_end: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && step_cnt_ff == STEP_W'(DIV_STEPS - 1)) |=> state_ff == ST_DONE)
      else $error("division did not finish after its last step");
`endif

endmodule

@@ hw/rtl/umean_dp.sv @@
// Datapath for the unsigned 16-bit mean block: accumulator, divider, result register.
module umean_dp (
   input  logic                     clock,
   input  logic                     reset,
   input  umean_pkg::umean_req_type req_data,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output umean_pkg::umean_rsp_type rsp_data,
   input  umean_pkg::umean_cmd_type cmd,
   output umean_pkg::umean_sts_type sts
);
   import umean_pkg::*;

   logic [31:0]   sum_ff, sum_in;
   logic [15:0]   count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [31:0]   sum_nx;
   logic [15:0]   count_nx;
   logic          ovf_nx;
   logic          sat;

   logic [15:0]   rem_ff, rem_in;
   logic [15:0]   shreg_ff, shreg_in;
   logic [15:0]   dvsr_ff, dvsr_in;
   logic          div_ovf_ff, div_ovf_in;
   logic [16:0]   trial;
   logic [16:0]   diff;
   logic          ge;

   logic          rsp_valid_ff, rsp_valid_in;
   umean_rsp_type rsp_data_ff, rsp_data_in;

   // Status back to the controller
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;
   assign sts.item_last  = req_data.last;
   assign sts.item_empty = req_data.empty_set;

   // Running set with saturating count
   assign sat      = (count_ff >= MAX_ELEMENTS);
   assign sum_nx   = sat ? sum_ff : sum_ff + {16'd0, req_data.sample};
   assign count_nx = sat ? count_ff : count_ff + 16'd1;
   assign ovf_nx   = ovf_ff | sat;

   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (cmd.clear || cmd.div_load) begin
         sum_in   = '0;
         count_in = '0;
         ovf_in   = 1'b0;
      end else if (cmd.acc_en) begin
         sum_in   = sum_nx;
         count_in = count_nx;
         ovf_in   = ovf_nx;
      end
   end

   // Restoring divider: high half of the sum is below the count, so 16 steps
   assign trial = {rem_ff, shreg_ff[15]};
   assign diff  = trial - {1'b0, dvsr_ff};
   assign ge    = (trial >= {1'b0, dvsr_ff});

   always_comb begin
      rem_in     = rem_ff;
      shreg_in   = shreg_ff;
      dvsr_in    = dvsr_ff;
      div_ovf_in = div_ovf_ff;
      if (cmd.div_load) begin
         rem_in     = sum_nx[31:16];
         shreg_in   = sum_nx[15:0];
         dvsr_in    = count_nx;
         div_ovf_in = ovf_nx;
      end else if (cmd.div_step) begin
         rem_in   = ge ? diff[15:0] : trial[15:0];
         shreg_in = {shreg_ff[14:0], ge};
      end
   end

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.out_load_zero) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.mean     = '0;
         rsp_data_in.overflow = 1'b0;
      end else if (cmd.out_load_div) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.mean     = shreg_ff;
         rsp_data_in.overflow = div_ovf_ff;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Control and set state
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      shreg_ff    <= shreg_in;
      dvsr_ff     <= dvsr_in;
      div_ovf_ff  <= div_ovf_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef NO_ASSERTIONS
   // Partial remainder stays below the divisor, so the quotient fits 16 bits
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (rem_ff < dvsr_ff))
      else $error("divider remainder out of range");

   // Overflow only ever goes with a saturated count
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (count_ff == MAX_ELEMENTS))
      else $error("overflow flag without saturated count");

   // The set is empty again after a last or empty-set word
   a_set_clear: assert property (@(posedge clock) disable iff (reset)
      (cmd.div_load || cmd.clear) |=> (sum_ff == '0 && count_ff == '0 && !ovf_ff))
      else $error("set state not cleared at end of set");
`endif

endmodule

@@ hw/rtl/unsigned_mean_u16.sv @@
// An empty-set word sets the result as it is taken; a last word sets it after the division.
// Throughput: one sample word per cycle while a set is accumulated and the result register is
// free; after a last word the input stalls while the restoring divider makes one quotient bit
// per cycle. The result sits in an output register, so a waiting result blocks only new words.
// Reset (synchronous, active high) clears the running sum, count, overflow flag and result valid.
module unsigned_mean_u16 (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  umean_pkg::umean_req_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output umean_pkg::umean_rsp_type rsp_data
);
   import umean_pkg::*;

   umean_cmd_type cmd;
   umean_sts_type sts;

   // Sequencing
   umean_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // Accumulator, divider and result register
   umean_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

@@ tb/unsigned_mean_u16_tb.sv @@
// Self-checking testbench for the unsigned 16-bit truncating mean block.
module unsigned_mean_u16_tb;
   import umean_pkg::*;

   localparam int IDLE_PCT      = 29;
   localparam int LONG_WORDS    = 256;
   localparam int RANDOM_WORDS  = 1470;
   localparam int QUIET_WORDS   = 300;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int REPORT_LIMIT  = 10;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   umean_req_type req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   umean_rsp_type rsp_data;

   // No idling on either side while set
   bit quiet = 1'b0;

   // Expected means, oldest first
   umean_rsp_type mean_q[$];

   // Shadow of the set being accumulated
   logic [31:0] sum_acc   = '0;
   logic [15:0] count_acc = '0;
   logic        ovf_acc   = 1'b0;

   int words_sent     = 0;
   int means_checked  = 0;
   int mismatch_count = 0;
   int idle_cycles    = 0;

   unsigned_mean_u16 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Update the shadow set with one accepted word; queue a mean when a set closes
   function automatic void track_word(umean_req_type w);
      umean_rsp_type r;
      logic [31:0]   quotient;
      if (w.empty_set) begin
         r.mean     = '0;
         r.overflow = 1'b0;
         mean_q.push_back(r);
         sum_acc   = '0;
         count_acc = '0;
         ovf_acc   = 1'b0;
      end else begin
         if (count_acc < MAX_ELEMENTS) begin
            sum_acc   = sum_acc + {16'd0, w.sample};
            count_acc = count_acc + 16'd1;
         end else begin
            ovf_acc = 1'b1;
         end
         if (w.last) begin
            quotient   = sum_acc / {16'd0, count_acc};
            r.mean     = quotient[15:0];
            r.overflow = ovf_acc;
            mean_q.push_back(r);
            sum_acc   = '0;
            count_acc = '0;
            ovf_acc   = 1'b0;
         end
      end
   endfunction

   function automatic umean_req_type mk_word(logic [15:0] s, logic l, logic e);
      umean_req_type w;
      w.sample    = s;
      w.last      = l;
      w.empty_set = e;
      return w;
   endfunction

   // Bias toward the ends of the range
   function automatic logic [15:0] pick_sample();
      logic [15:0] s;
      case ($urandom_range(7))
         0: s = 16'h0000;
         1: s = 16'hFFFF;
         2: s = 16'($urandom_range(65535, 60000));
         3: s = 16'($urandom_range(15));
         default: s = 16'($urandom);
      endcase
      return s;
   endfunction

   // Drive one word at the falling edge, hold it until taken
   task automatic send_word(input umean_req_type w);
      @(negedge clock);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      words_sent++;
      track_word(w);
   endtask

   // Receiver stall
   always @(negedge clock) begin
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
   end

   // Result check and watchdog
   always @(posedge clock) begin
      umean_rsp_type exp_w;
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (mean_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("ERROR: unexpected result mean=%0d overflow=%0b",
                           rsp_data.mean, rsp_data.overflow);
            end else begin
               exp_w = mean_q.pop_front();
               means_checked++;
               if (rsp_data.mean !== exp_w.mean || rsp_data.overflow !== exp_w.overflow) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"ERROR: result %0d expected mean=%0d overflow=%0b,",
                               " got mean=%0d overflow=%0b"},
                              means_checked, exp_w.mean, exp_w.overflow,
                              rsp_data.mean, rsp_data.overflow);
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= STALL_LIMIT) begin
            $display("ERROR: no word moved for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Range ends, truncation, empty sets and a set cut short by an empty word
   task automatic test_directed();
      send_word(mk_word(16'h0000, 1'b1, 1'b0));
      send_word(mk_word(16'hFFFF, 1'b1, 1'b0));
      send_word(mk_word(16'hFFFF, 1'b0, 1'b0));
      send_word(mk_word(16'hFFFF, 1'b1, 1'b0));
      send_word(mk_word(16'h0000, 1'b0, 1'b0));
      send_word(mk_word(16'hFFFF, 1'b1, 1'b0));
      send_word(mk_word(16'd1, 1'b0, 1'b0));
      send_word(mk_word(16'd2, 1'b1, 1'b0));
      send_word(mk_word(16'hAAAA, 1'b1, 1'b0));
      send_word(mk_word(16'h5555, 1'b1, 1'b0));
      // empty word ignores sample and last
      send_word(mk_word(16'hFFFF, 1'b1, 1'b1));
      send_word(mk_word(16'h0000, 1'b0, 1'b1));
      // partial set dropped by an empty word
      send_word(mk_word(16'd100, 1'b0, 1'b0));
      send_word(mk_word(16'd200, 1'b0, 1'b0));
      send_word(mk_word(16'h1234, 1'b0, 1'b1));
      send_word(mk_word(16'd7, 1'b1, 1'b0));
      // power-of-two count
      send_word(mk_word(16'd3, 1'b0, 1'b0));
      send_word(mk_word(16'd5, 1'b0, 1'b0));
      send_word(mk_word(16'd7, 1'b0, 1'b0));
      send_word(mk_word(16'd9, 1'b1, 1'b0));
      send_word(mk_word(16'hFFFF, 1'b0, 1'b0));
      send_word(mk_word(16'hFFFF, 1'b0, 1'b0));
      send_word(mk_word(16'hFFFE, 1'b1, 1'b0));
   endtask

   // Long set of full-scale samples: wide sum, mean at the top of the range
   task automatic test_long_set();
      quiet = 1'b1;
      for (int i = 0; i < LONG_WORDS; i++)
         send_word(mk_word(16'hFFFF, i == LONG_WORDS - 1, 1'b0));
      quiet = 1'b0;
   endtask

   // Random sets, stray empty words and sets broken off midway
   task automatic test_random_sets();
      int sent;
      int len;
      sent  = 0;
      quiet = 1'b1;
      while (sent < RANDOM_WORDS) begin
         if (sent >= QUIET_WORDS)
            quiet = 1'b0;
         if ($urandom_range(99) < 8) begin
            send_word(mk_word(16'($urandom), 1'($urandom), 1'b1));
            sent++;
         end else begin
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            for (int i = 0; i < len; i++) begin
               if (i > 0 && $urandom_range(99) < 3) begin
                  send_word(mk_word(16'($urandom), 1'($urandom), 1'b1));
                  sent++;
                  break;
               end
               send_word(mk_word(pick_sample(), i == len - 1, 1'b0));
               sent++;
            end
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_long_set();
      test_random_sets();

      @(negedge clock);
      req_valid <= 1'b0;
      while (mean_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mean_q.size() != 0)
         mismatch_count++;

      $display("Sent %0d words, checked %0d means, including a %0d-sample full-scale set",
               words_sent, means_checked, LONG_WORDS);
      $display("Mismatches: %0d", mismatch_count);
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
